// File: hdl/shash_pkg.sv
`timescale 1ns / 1ps

package shash_pkg;

    // Geometry of one block and of the chaining state
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;

    // Input item: one message byte or a finish request
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } msg_item_t;

    // Result item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    // Input modes
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT_READ,
        ST_OUT_LOAD
    } state_t;

    localparam logic [31:0] HASH_INIT [0:HASH_WORDS-1] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// File: hdl/shash_ram.sv
`timescale 1ns / 1ps

module shash_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/sha256_stream_hash_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// msg       in         msg_valid / msg_stall  msg_item_t: mode, data_byte
// dig       out        dig_valid / dig_stall  digest_item_t: digest_word, word_index, last_word
//
// An absorb byte is accepted whenever the controller is idle; the byte that completes a block
// starts a compression (loading the block and hash memories, 64 rounds, writing back the
// hash memory), during which msg_stall is high.
// A finish writes the padding words, runs one or two compressions, then reads the hash
// memory out through ST_OUT_READ and ST_OUT_LOAD for each digest word while dig_stall is low.
// msg_stall is high whenever the controller is not idle; reset needs no clearing pass.
// The digest leaves through an output register, so bytes of the next message are taken
// while the last digest word still waits.

module sha256_stream_hash_top
    import shash_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_item_t    msg,
    output logic         dig_valid,
    input  logic         dig_stall,
    output digest_item_t dig
);

    localparam int BA = $clog2(BLOCK_WORDS);
    localparam int HA = $clog2(HASH_WORDS);

    // Control state
    state_t            state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       bits_reg, bits_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [5:0]        round_reg, round_next;
    logic [BA-1:0]     pad_idx_reg, pad_idx_next;
    logic              first_reg, first_next;
    logic              spill_reg, spill_next;
    logic              finishing_reg, finishing_next;
    logic [HA-1:0]     out_idx_reg, out_idx_next;
    logic [HASH_WORDS-1:0] hvalid_reg, hvalid_next;
    logic              dig_valid_reg, dig_valid_next;

    // Payload state
    logic [23:0]       part_reg, part_next;
    logic [31:0]       win_reg [BLOCK_WORDS];
    logic [31:0]       win_next [BLOCK_WORDS];
    logic [31:0]       work_reg [HASH_WORDS];
    logic [31:0]       work_next [HASH_WORDS];
    logic [HA-1:0]     hraddr_d_reg;
    digest_item_t      dig_reg, dig_next;

    // Memory ports
    logic              blk_we;
    logic [BA-1:0]     blk_waddr;
    logic [31:0]       blk_wdata;
    logic [BA-1:0]     blk_raddr;
    logic [31:0]       blk_rdata;
    logic              hash_we;
    logic [HA-1:0]     hash_waddr;
    logic [31:0]       hash_wdata;
    logic [HA-1:0]     hash_raddr;
    logic [31:0]       hash_rdata;
    logic [31:0]       hash_q;

    logic              msg_xfer;
    logic              dig_xfer;
    logic [31:0]       pad_word;
    logic [31:0]       t1;
    logic [31:0]       t2;
    logic [31:0]       w_new;

    shash_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk     (clk),
        .wr_en   (blk_we),
        .wr_addr (blk_waddr),
        .wr_data (blk_wdata),
        .rd_addr (blk_raddr),
        .rd_data (blk_rdata)
    );

    shash_ram #(
        .WIDTH (32),
        .DEPTH (HASH_WORDS)
    ) u_hash_ram (
        .clk     (clk),
        .wr_en   (hash_we),
        .wr_addr (hash_waddr),
        .wr_data (hash_wdata),
        .rd_addr (hash_raddr),
        .rd_data (hash_rdata)
    );

    assign msg_stall = (state_reg != ST_IDLE);
    assign msg_xfer  = msg_valid && !msg_stall;
    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;
    assign dig_xfer  = dig_valid_reg && !dig_stall;

    // Substitute the initial value for a hash word not yet written
    assign hash_q = hvalid_reg[hraddr_d_reg] ? hash_rdata : HASH_INIT[hraddr_d_reg];

    // Build the first padding word from the buffered bytes and the marker
    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: pad_word = {PAD_MARK, 24'h0};
            2'd1: pad_word = {part_reg[7:0], PAD_MARK, 16'h0};
            2'd2: pad_word = {part_reg[15:0], PAD_MARK, 8'h0};
            2'd3: pad_word = {part_reg[23:0], PAD_MARK};
        endcase
    end

    // Round datapath and message schedule
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6])
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9]
                 + small_sigma0(win_reg[1]) + win_reg[0];

    // Next state, memory accesses and register updates
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        pad_idx_next   = pad_idx_reg;
        first_next     = first_reg;
        spill_next     = spill_reg;
        finishing_next = finishing_reg;
        out_idx_next   = out_idx_reg;
        hvalid_next    = hvalid_reg;
        dig_valid_next = dig_xfer ? 1'b0 : dig_valid_reg;
        part_next      = part_reg;
        win_next       = win_reg;
        work_next      = work_reg;
        dig_next       = dig_reg;

        blk_we     = 1'b0;
        blk_waddr  = fill_reg[5:2];
        blk_wdata  = {part_reg, msg.data_byte};
        blk_raddr  = cnt_reg[BA-1:0];
        hash_we    = 1'b0;
        hash_waddr = hraddr_d_reg;
        hash_wdata = hash_q + work_reg[hraddr_d_reg];
        hash_raddr = cnt_reg[HA-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_xfer && msg.mode == MODE_ABSORB)
                begin
                    // Pack bytes big-endian; store every fourth
                    part_next = {part_reg[15:0], msg.data_byte};
                    blk_we    = (fill_reg[1:0] == 2'd3);
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        finishing_next = 1'b0;
                        cnt_next       = '0;
                        state_next     = ST_LOAD;
                    end
                end
                else if (msg_xfer)
                begin
                    // Latch total length and plan the padding
                    bits_next      = bits_reg + {55'h0, fill_reg, 3'h0};
                    spill_next     = (fill_reg[5:3] == 3'b111);
                    first_next     = 1'b1;
                    pad_idx_next   = fill_reg[5:2];
                    finishing_next = 1'b1;
                    state_next     = ST_PAD;
                end
            end

            ST_PAD:
            begin
                // Write one padding word per cycle
                blk_we    = 1'b1;
                blk_waddr = pad_idx_reg;
                if (first_reg)
                begin
                    blk_wdata = pad_word;
                end
                else if (!spill_reg && pad_idx_reg == BA'(BLOCK_WORDS - 2))
                begin
                    blk_wdata = bits_reg[63:32];
                end
                else if (!spill_reg && pad_idx_reg == BA'(BLOCK_WORDS - 1))
                begin
                    blk_wdata = bits_reg[31:0];
                end
                else
                begin
                    blk_wdata = '0;
                end
                first_next   = 1'b0;
                pad_idx_next = pad_idx_reg + BA'(1);
                if (pad_idx_reg == BA'(BLOCK_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                // Stream block words into the window, hash words into the working set
                if (cnt_reg != '0)
                begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[BLOCK_WORDS-1] = blk_rdata;
                    if (cnt_reg <= 5'(HASH_WORDS))
                    begin
                        work_next[hraddr_d_reg] = hash_q;
                    end
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(BLOCK_WORDS))
                begin
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                // One compression round; advance the schedule window
                work_next[0] = t1 + t2;
                work_next[1] = work_reg[0];
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3] + t1;
                work_next[5] = work_reg[4];
                work_next[6] = work_reg[5];
                work_next[7] = work_reg[6];
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = w_new;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // Read, add and write back each hash word
                if (cnt_reg != '0)
                begin
                    hash_we                   = 1'b1;
                    hvalid_next[hraddr_d_reg] = 1'b1;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(HASH_WORDS))
                begin
                    if (!finishing_reg)
                    begin
                        bits_next  = bits_reg + 64'd512;
                        state_next = ST_IDLE;
                    end
                    else if (spill_reg)
                    begin
                        spill_next   = 1'b0;
                        pad_idx_next = '0;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT_READ;
                    end
                end
            end

            ST_OUT_READ:
            begin
                // Fetch the next digest word once the output register frees up
                hash_raddr = out_idx_reg;
                if (!dig_valid_reg || !dig_stall)
                begin
                    state_next = ST_OUT_LOAD;
                end
            end

            ST_OUT_LOAD:
            begin
                dig_next.digest_word = hash_q;
                dig_next.word_index  = out_idx_reg;
                dig_next.last_word   = (out_idx_reg == HA'(HASH_WORDS - 1));
                dig_valid_next       = 1'b1;
                out_idx_next         = out_idx_reg + HA'(1);
                if (out_idx_reg == HA'(HASH_WORDS - 1))
                begin
                    // Drop the message and return to the initial hash
                    hvalid_next    = '0;
                    fill_next      = '0;
                    bits_next      = '0;
                    finishing_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUT_READ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            cnt_reg       <= '0;
            round_reg     <= '0;
            pad_idx_reg   <= '0;
            first_reg     <= 1'b0;
            spill_reg     <= 1'b0;
            finishing_reg <= 1'b0;
            out_idx_reg   <= '0;
            hvalid_reg    <= '0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            pad_idx_reg   <= pad_idx_next;
            first_reg     <= first_next;
            spill_reg     <= spill_next;
            finishing_reg <= finishing_next;
            out_idx_reg   <= out_idx_next;
            hvalid_reg    <= hvalid_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        part_reg     <= part_next;
        win_reg      <= win_next;
        work_reg     <= work_next;
        hraddr_d_reg <= hash_raddr;
        dig_reg      <= dig_next;
    end

    // A finish transfer starts the padding pass
    a_finish_pads: assert property (@(posedge clk) disable iff (!rst_n)
        msg_xfer && msg.mode == MODE_FINISH |=> state_reg == ST_PAD)
        else $error("finish did not start padding");

    // The output register is free whenever a digest word is loaded
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT_LOAD |-> !dig_valid_reg)
        else $error("digest word overwrote a pending word");

    // The last word flag marks word seven only
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> dig.last_word == (dig.word_index == HA'(HASH_WORDS - 1)))
        else $error("last_word does not match word_index");

    // After the final digest word the message state is back at its start
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT_LOAD && out_idx_reg == HA'(HASH_WORDS - 1)
        |=> hvalid_reg == '0 && fill_reg == '0 && bits_reg == '0)
        else $error("message state not cleared after digest");

    // Rounds run without a break until the last one
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_reg != 6'(ROUNDS - 1) |=> state_reg == ST_ROUND)
        else $error("compression rounds interrupted");

endmodule
